/* hdl/ncmq_pkg.sv */
`default_nettype none

package ncmq_pkg;

    // field widths
    localparam int POS_W   = 11;
    localparam int PRICE_W = 30;
    localparam int COST_W  = 31;
    localparam int VAL_W   = 32;

    // default tree capacity and register reset
    localparam int NCMQ_CAPACITY = 1024;
    localparam logic [POS_W-1:0] POS_RESET = 11'd1024;

    // empty tree node
    localparam logic signed [VAL_W-1:0] TREE_INF = 32'sh7FFF_FFFF;

    // item kinds
    localparam logic KIND_SET   = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // tree walker states
    typedef enum logic [2:0] {
        TS_CLEAR,
        TS_IDLE,
        TS_UP_RD,
        TS_UP_WR,
        TS_QRY_RD,
        TS_QRY_ACC
    } t_tree_state;

    // top sequencer states
    typedef enum logic [1:0] {
        TP_IDLE,
        TP_WAIT,
        TP_SUM,
        TP_PICK
    } t_top_state;

    // command from the sequencer to a tree
    typedef struct packed {
        logic start;
        logic query;
    } t_tree_ctrl;

endpackage

`default_nettype wire

/* hdl/ncmq_tree.sv */
`default_nettype none

module ncmq_tree
    import ncmq_pkg::*;
#(
    parameter int CAPACITY = NCMQ_CAPACITY
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_tree_ctrl              i_ctrl,
    input  wire logic [$clog2(2*CAPACITY):0] i_lo,
    input  wire logic [$clog2(2*CAPACITY):0] i_hi,
    input  wire logic signed [VAL_W-1:0] i_value,
    output logic                         o_ready,
    output logic signed [VAL_W-1:0]      o_min
);

    localparam int AW = $clog2(2*CAPACITY);
    localparam int IW = AW + 1;

    // node store, leaf of position p at CAPACITY + p - 1
    logic signed [VAL_W-1:0] mem [2*CAPACITY];

    t_tree_state             r_state;
    t_tree_state             n_state;
    logic [AW-1:0]           r_clr;
    logic [IW-1:0]           r_a;
    logic [IW-1:0]           r_b;
    logic signed [VAL_W-1:0] r_res;
    logic signed [VAL_W-1:0] r_rd0;
    logic signed [VAL_W-1:0] r_rd1;

    logic                    w_we;
    logic [AW-1:0]           w_waddr;
    logic signed [VAL_W-1:0] w_wdata;
    logic                    w_rd_en;
    logic [AW-1:0]           w_raddr0;
    logic [AW-1:0]           w_raddr1;
    logic [IW-1:0]           w_b_dec;
    logic signed [VAL_W-1:0] w_pair_min;
    logic signed [VAL_W-1:0] w_ca;
    logic signed [VAL_W-1:0] w_cb;
    logic signed [VAL_W-1:0] w_cab;
    logic signed [VAL_W-1:0] w_acc;

    // shared min unit
    always_comb begin
        w_b_dec    = r_b - IW'(1);
        w_pair_min = (r_rd0 < r_rd1) ? r_rd0 : r_rd1;
        w_ca       = r_a[0] ? r_rd0 : TREE_INF;
        w_cb       = r_b[0] ? r_rd1 : TREE_INF;
        w_cab      = (w_ca < w_cb) ? w_ca : w_cb;
        w_acc      = (w_cab < r_res) ? w_cab : r_res;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            TS_CLEAR: begin
                if (r_clr == AW'(2*CAPACITY-1)) n_state = TS_IDLE;
            end
            TS_IDLE: begin
                if (i_ctrl.start) n_state = i_ctrl.query ? TS_QRY_RD : TS_UP_RD;
            end
            TS_UP_RD:   n_state = TS_UP_WR;
            TS_UP_WR: begin
                n_state = ((r_a >> 1) == '0) ? TS_IDLE : TS_UP_RD;
            end
            TS_QRY_RD: begin
                n_state = (r_a < r_b) ? TS_QRY_ACC : TS_IDLE;
            end
            TS_QRY_ACC: n_state = TS_QRY_RD;
            default:    n_state = TS_IDLE;
        endcase
    end

    // memory port control
    always_comb begin
        w_we     = 1'b0;
        w_waddr  = r_a[AW-1:0];
        w_wdata  = w_pair_min;
        w_rd_en  = 1'b0;
        w_raddr0 = r_a[AW-1:0];
        w_raddr1 = w_b_dec[AW-1:0];
        case (r_state)
            TS_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = TREE_INF;
            end
            TS_IDLE: begin
                w_we    = i_ctrl.start && !i_ctrl.query;
                w_waddr = i_lo[AW-1:0];
                w_wdata = i_value;
            end
            TS_UP_RD: begin
                w_rd_en  = 1'b1;
                w_raddr0 = {r_a[AW-2:0], 1'b0};
                w_raddr1 = {r_a[AW-2:0], 1'b1};
            end
            TS_UP_WR: begin
                w_we = 1'b1;
            end
            TS_QRY_RD: begin
                w_rd_en = (r_a < r_b);
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // node store ports, registered read data
    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_waddr] <= w_wdata;
        if (w_rd_en) begin
            r_rd0 <= mem[w_raddr0];
            r_rd1 <= mem[w_raddr1];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= TS_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == TS_CLEAR) r_clr <= r_clr + AW'(1);
        end
    end

    // walk indexes and running minimum
    always_ff @(posedge i_clk) begin
        case (r_state)
            TS_IDLE: begin
                if (i_ctrl.start) begin
                    if (i_ctrl.query) begin
                        r_a   <= i_lo;
                        r_b   <= i_hi;
                        r_res <= TREE_INF;
                    end else begin
                        r_a <= i_lo >> 1;
                    end
                end
            end
            TS_UP_WR: begin
                r_a <= r_a >> 1;
            end
            TS_QRY_ACC: begin
                r_res <= w_acc;
                r_a   <= (r_a + IW'(r_a[0])) >> 1;
                r_b   <= r_b >> 1;
            end
            default: begin
                r_a <= r_a;
            end
        endcase
    end

    assign o_ready = (r_state == TS_IDLE);
    assign o_min   = r_res;

endmodule

`default_nettype wire

/* hdl/nearest_cost_min_query_tree_top.sv */
`default_nettype none

// channel   direction  handshake           payload
// input     in         i_valid / o_stall   i_kind, i_position, i_price
// output    out        o_valid / i_stall   o_min_cost, o_found
// config    in         i_cfg_we            i_cfg_data (positions in use)
//
// a set writes its leaf, then the tree walkers climb one level at a time,
// bound by the node store ports: one level read, then one level written
// a query walks both trees in parallel, one level per read and accumulate pair
// after reset both stores are cleared to empty nodes, with o_stall high
// a finished result waits in the output register while the next item transfers

module nearest_cost_min_query_tree_top
    import ncmq_pkg::*;
#(
    parameter int CAPACITY = NCMQ_CAPACITY
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic               i_kind,
    input  wire logic [POS_W-1:0]   i_position,
    input  wire logic [PRICE_W-1:0] i_price,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [COST_W-1:0]       o_min_cost,
    output logic                    o_found,
    input  wire logic               i_cfg_we,
    input  wire logic [POS_W-1:0]   i_cfg_data
);

    localparam int AW = $clog2(2*CAPACITY);
    localparam int IW = AW + 1;
    localparam int CW = (AW > POS_W) ? AW : POS_W;

    t_top_state              r_state;
    t_top_state              n_state;
    logic [POS_W-1:0]        r_positions;
    logic [POS_W-1:0]        r_k;
    logic                    r_found_l;
    logic                    r_found_r;
    logic signed [VAL_W:0]   r_cost_l;
    logic signed [VAL_W:0]   r_cost_r;
    logic                    r_o_valid;
    logic [COST_W-1:0]       r_o_cost;
    logic                    r_o_found;

    t_tree_ctrl              w_ctrl;
    logic                    w_ready_l;
    logic                    w_ready_r;
    logic signed [VAL_W-1:0] w_min_l;
    logic signed [VAL_W-1:0] w_min_r;
    logic                    w_accept;
    logic                    w_load;
    logic [CW-1:0]           w_n;
    logic [CW-1:0]           w_k;
    logic [CW-1:0]           w_kn;
    logic [IW-1:0]           w_cap;
    logic [IW-1:0]           w_leaf;
    logic                    w_set_ok;
    logic [IW-1:0]           w_lo_l;
    logic [IW-1:0]           w_hi_l;
    logic [IW-1:0]           w_lo_r;
    logic [IW-1:0]           w_hi_r;
    logic signed [VAL_W-1:0] w_val_l;
    logic signed [VAL_W-1:0] w_val_r;
    logic signed [VAL_W:0]   w_best;

    // covered range and tree index math
    always_comb begin
        w_n      = (CW'(r_positions) > CW'(CAPACITY)) ? CW'(CAPACITY) : CW'(r_positions);
        w_k      = CW'(i_position);
        w_kn     = (w_k < w_n) ? w_k : w_n;
        w_cap    = IW'(CAPACITY);
        w_leaf   = w_cap + IW'(w_k) - IW'(1);
        w_set_ok = (w_k != '0) && (w_k <= w_n);
        w_val_l  = $signed({2'b00, i_price}) - $signed({{(VAL_W-POS_W){1'b0}}, i_position});
        w_val_r  = $signed({2'b00, i_price}) + $signed({{(VAL_W-POS_W){1'b0}}, i_position});
        if (i_kind == KIND_QUERY) begin
            w_lo_l = w_cap;
            w_hi_l = w_cap + IW'(w_kn);
            w_lo_r = w_cap + IW'(w_kn);
            w_hi_r = w_cap + IW'(w_n);
        end else begin
            w_lo_l = w_leaf;
            w_hi_l = w_leaf;
            w_lo_r = w_leaf;
            w_hi_r = w_leaf;
        end
    end

    // input handshake
    always_comb begin
        o_stall      = !((r_state == TP_IDLE) && w_ready_l && w_ready_r);
        w_accept     = i_valid && !o_stall;
        w_ctrl.query = (i_kind == KIND_QUERY);
        w_ctrl.start = w_accept && ((i_kind == KIND_QUERY) || w_set_ok);
    end

    ncmq_tree #(
        .CAPACITY (CAPACITY)
    ) u_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_lo    (w_lo_l),
        .i_hi    (w_hi_l),
        .i_value (w_val_l),
        .o_ready (w_ready_l),
        .o_min   (w_min_l)
    );

    ncmq_tree #(
        .CAPACITY (CAPACITY)
    ) u_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_lo    (w_lo_r),
        .i_hi    (w_hi_r),
        .i_value (w_val_r),
        .o_ready (w_ready_r),
        .o_min   (w_min_r)
    );

    // pick the cheaper found side, a negative cost clamps to zero
    always_comb begin
        if (r_found_l && r_found_r) begin
            w_best = (r_cost_r < r_cost_l) ? r_cost_r : r_cost_l;
        end else if (r_found_l) begin
            w_best = r_cost_l;
        end else if (r_found_r) begin
            w_best = r_cost_r;
        end else begin
            w_best = '0;
        end
        if (w_best < 0) w_best = '0;
        w_load = (r_state == TP_PICK) && (!r_o_valid || !i_stall);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            TP_IDLE: begin
                if (w_accept && (i_kind == KIND_QUERY)) n_state = TP_WAIT;
            end
            TP_WAIT: begin
                if (w_ready_l && w_ready_r) n_state = TP_SUM;
            end
            TP_SUM:  n_state = TP_PICK;
            TP_PICK: begin
                if (w_load) n_state = TP_IDLE;
            end
            default: n_state = TP_IDLE;
        endcase
    end

    // control state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= TP_IDLE;
            r_positions <= POS_RESET;
            r_o_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_positions <= i_cfg_data;
            if (w_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // query position, side costs and output payload
    always_ff @(posedge i_clk) begin
        if (w_accept) r_k <= i_position;
        if (r_state == TP_SUM) begin
            r_found_l <= (w_min_l != TREE_INF);
            r_found_r <= (w_min_r != TREE_INF);
            r_cost_l  <= $signed({w_min_l[VAL_W-1], w_min_l})
                       + $signed({{(VAL_W+1-POS_W){1'b0}}, r_k});
            r_cost_r  <= $signed({w_min_r[VAL_W-1], w_min_r})
                       - $signed({{(VAL_W+1-POS_W){1'b0}}, r_k});
        end
        if (w_load) begin
            r_o_cost  <= w_best[COST_W-1:0];
            r_o_found <= r_found_l || r_found_r;
        end
    end

    assign o_valid    = r_o_valid;
    assign o_min_cost = r_o_cost;
    assign o_found    = r_o_found;

endmodule

`default_nettype wire
